// ===== hdl/vector_normalize_unit_assert.svh =====
// assertion macros for the vector normalize unit
`ifndef VECTOR_NORMALIZE_UNIT_ASSERT_SVH
`define VECTOR_NORMALIZE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VNU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define VNU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vnu_pkg.sv =====
// package with widths, register codes and helpers of the vector normalize unit
`timescale 1ns / 1ps

package vnu_pkg;

    localparam int COMP_W   = 32;
    localparam int MIN_W    = 32;
    localparam int SEL_W    = 3;
    localparam int ROOT_W   = 33;
    localparam int REM_W    = 67;
    localparam int NUM_W    = 63;
    localparam int Q_W      = 31;
    localparam int FRAC_OUT = 30;
    localparam int LANES    = 4;

    localparam logic [SEL_W-1:0] ACTIVE_RESET = 3'd3;

    typedef enum logic {
        REG_ACTIVE = 1'b0,
        REG_MIN    = 1'b1
    } t_reg_index;

    // lane enable mask from the raw selector, out of range values clamp
    function automatic logic [LANES-1:0] active_mask(input logic [SEL_W-1:0] sel);
        logic [LANES-1:0] m;
        if (sel <= 3'd2) begin
            m = 4'b0011;
        end else if (sel == 3'd3) begin
            m = 4'b0111;
        end else begin
            m = 4'b1111;
        end
        return m;
    endfunction

endpackage

// ===== hdl/vector_normalize_unit.sv =====
// top level of the vector normalize unit: squares, sum, root and divide pipeline
`timescale 1ns / 1ps
`include "vector_normalize_unit_assert.svh"

//  channel   handshake                 payload
//  input     i_in_valid / o_in_stall    i_comp_x .. i_comp_w
//  output    o_out_valid / i_out_stall  o_unit_x .. o_unit_w, o_too_short
//  config    psel penable pwrite pready paddr pwdata prdata
//
//  one item per cycle while the output is not stalled; stages: magnitude, square, sum,
//  33 square root stages (one root bit each), compare, 31 divide stages
//  (one quotient bit each) and the output register
//  synchronous active low reset clears the valid bits and the config registers
//  a stall at the output while it holds valid data freezes every stage and stalls the input

module vector_normalize_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [31:0] i_comp_x,
    input  logic signed [31:0] i_comp_y,
    input  logic signed [31:0] i_comp_z,
    input  logic signed [31:0] i_comp_w,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_unit_x,
    output logic signed [31:0] o_unit_y,
    output logic signed [31:0] o_unit_z,
    output logic signed [31:0] o_unit_w,
    output logic        o_too_short,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int L  = vnu_pkg::LANES;
    localparam int CW = vnu_pkg::COMP_W;
    localparam int RW = vnu_pkg::ROOT_W;
    localparam int MW = vnu_pkg::REM_W;
    localparam int NW = vnu_pkg::NUM_W;
    localparam int QW = vnu_pkg::Q_W;

    logic [vnu_pkg::SEL_W-1:0] r_active;
    logic [vnu_pkg::MIN_W-1:0] r_min_len;
    logic                      adv;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= vnu_pkg::ACTIVE_RESET;
            r_min_len <= '0;
        end else if (wr_en) begin
            unique case (vnu_pkg::t_reg_index'(paddr[2]))
                vnu_pkg::REG_ACTIVE: r_active  <= pwdata[vnu_pkg::SEL_W-1:0];
                vnu_pkg::REG_MIN:    r_min_len <= pwdata;
                default:             r_active  <= r_active;
            endcase
        end
    end

    always_comb begin
        unique case (vnu_pkg::t_reg_index'(paddr[2]))
            vnu_pkg::REG_ACTIVE: prdata = {29'd0, r_active};
            vnu_pkg::REG_MIN:    prdata = r_min_len;
            default:             prdata = '0;
        endcase
    end

    logic r_out_valid;
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    // stage a: magnitudes and lane mask
    logic                 r_a_valid;
    logic [L-1:0][CW-1:0] r_a_mag;
    logic [L-1:0]         r_a_neg;
    logic [L-1:0]         r_a_mask;
    logic [L-1:0][CW-1:0] comp_in;

    assign comp_in = {i_comp_w, i_comp_z, i_comp_y, i_comp_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_mask <= vnu_pkg::active_mask(r_active);
            for (int i = 0; i < L; i++) begin
                r_a_neg[i] <= comp_in[i][CW-1];
                r_a_mag[i] <= comp_in[i][CW-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
            end
        end
    end

    // stage b: squares
    logic                   r_b_valid;
    logic [L-1:0][2*CW-1:0] r_b_sq;
    logic [L-1:0][CW-1:0]   r_b_mag;
    logic [L-1:0]           r_b_neg;
    logic [L-1:0]           r_b_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_mask <= r_a_mask;
            for (int i = 0; i < L; i++) begin
                r_b_sq[i] <= r_a_mask[i] ? r_a_mag[i] * r_a_mag[i] : '0;
            end
        end
    end

    // stage c and root stages share arrays, index 0 holds the sum
    logic                 r_s_valid [0:RW];
    logic [MW-1:0]        r_s_rem   [0:RW];
    logic [RW-1:0]        r_s_root  [0:RW];
    logic [L-1:0][CW-1:0] r_s_mag   [0:RW];
    logic [L-1:0]         r_s_neg   [0:RW];
    logic [L-1:0]         r_s_mask  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
        end else if (adv) begin
            r_s_valid[0] <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s_rem[0]  <= MW'(r_b_sq[0]) + MW'(r_b_sq[1]) + MW'(r_b_sq[2])
                         + MW'(r_b_sq[3]);
            r_s_root[0] <= '0;
            r_s_mag[0]  <= r_b_mag;
            r_s_neg[0]  <= r_b_neg;
            r_s_mask[0] <= r_b_mask;
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_root
        localparam int K = RW - 1 - j;
        logic [MW-1:0] trial;
        logic          take;

        assign trial = (MW'(r_s_root[j]) << (K + 1)) + (MW'(1) << (2 * K));
        assign take  = r_s_rem[j] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[j+1] <= 1'b0;
            end else if (adv) begin
                r_s_valid[j+1] <= r_s_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s_rem[j+1]  <= take ? r_s_rem[j] - trial : r_s_rem[j];
                r_s_root[j+1] <= take ? (r_s_root[j] | (RW'(1) << K)) : r_s_root[j];
                r_s_mag[j+1]  <= r_s_mag[j];
                r_s_neg[j+1]  <= r_s_neg[j];
                r_s_mask[j+1] <= r_s_mask[j];
            end
        end
    end

    // compare stage and divide stages, index 0 holds the rounded numerators
    logic                 r_d_valid [0:QW];
    logic [L-1:0][NW-1:0] r_d_rem   [0:QW];
    logic [L-1:0][QW-1:0] r_d_q     [0:QW];
    logic [RW-1:0]        r_d_len   [0:QW];
    logic                 r_d_short [0:QW];
    logic [L-1:0]         r_d_neg   [0:QW];
    logic [L-1:0]         r_d_mask  [0:QW];
    logic [RW-1:0]        len;

    assign len = r_s_root[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else if (adv) begin
            r_d_valid[0] <= r_s_valid[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_len[0]   <= len;
            r_d_short[0] <= len <= RW'(r_min_len);
            r_d_neg[0]   <= r_s_neg[RW];
            r_d_mask[0]  <= r_s_mask[RW];
            for (int i = 0; i < L; i++) begin
                r_d_rem[0][i] <= (NW'(r_s_mag[RW][i]) << vnu_pkg::FRAC_OUT)
                               + NW'(len >> 1);
                r_d_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        logic [NW-1:0] dshift;

        assign dshift = NW'(r_d_len[j]) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[j+1] <= 1'b0;
            end else if (adv) begin
                r_d_valid[j+1] <= r_d_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d_len[j+1]   <= r_d_len[j];
                r_d_short[j+1] <= r_d_short[j];
                r_d_neg[j+1]   <= r_d_neg[j];
                r_d_mask[j+1]  <= r_d_mask[j];
                for (int i = 0; i < L; i++) begin
                    if (r_d_rem[j][i] >= dshift) begin
                        r_d_rem[j+1][i] <= r_d_rem[j][i] - dshift;
                        r_d_q[j+1][i]   <= r_d_q[j][i] | (QW'(1) << K);
                    end else begin
                        r_d_rem[j+1][i] <= r_d_rem[j][i];
                        r_d_q[j+1][i]   <= r_d_q[j][i];
                    end
                end
            end
        end
    end

    // output register
    logic [L-1:0][CW-1:0] r_unit;
    logic                 r_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_d_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_short <= r_d_short[QW];
            for (int i = 0; i < L; i++) begin
                if (r_d_short[QW] || !r_d_mask[QW][i]) begin
                    r_unit[i] <= '0;
                end else if (r_d_neg[QW][i]) begin
                    r_unit[i] <= ~CW'(r_d_q[QW][i]) + 1'b1;
                end else begin
                    r_unit[i] <= CW'(r_d_q[QW][i]);
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_too_short = r_short;
    assign o_unit_x    = r_unit[0];
    assign o_unit_y    = r_unit[1];
    assign o_unit_z    = r_unit[2];
    assign o_unit_w    = r_unit[3];

    `VNU_ASSERT_SAME(a_short_zero, i_clk, i_rst_n, o_out_valid && o_too_short,
        o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0 && o_unit_w == 0,
        "short vector with nonzero output")
    `VNU_ASSERT_SAME(a_unit_range, i_clk, i_rst_n, o_out_valid,
        o_unit_x <= 32'sd1073741824 && o_unit_x >= -32'sd1073741824,
        "unit component out of range")
    `VNU_ASSERT_NEXT(a_advance, i_clk, i_rst_n, r_d_valid[QW] && adv,
        o_out_valid, "item lost at output stage")

endmodule
